### hdl/ptt_pkg.sv
// Shared types and codes for the periodic task timer table.
// Used by ptt_ctrl, ptt_datapath and periodic_task_timer_table; depends on nothing.
`default_nettype none

package ptt_pkg;

	localparam logic [1:0] FUNC_SCHED  = 2'd0;
	localparam logic [1:0] FUNC_TICK   = 2'd1;
	localparam logic [1:0] FUNC_REMOVE = 2'd2;

	localparam logic ACT_UPDATE = 1'b0;
	localparam logic ACT_NOOP   = 1'b1;

	typedef struct packed {
		logic [23:0] upd_per;
		logic [23:0] nop_per;
		logic [31:0] upd_cd;
		logic [31:0] nop_cd;
	} ptt_entry_t;

	typedef struct packed {
		logic sched;
		logic remove;
		logic tick_ld;
		logic rd_en;
		logic flush;
	} ptt_cmd_t;

	typedef struct packed {
		logic pend;
	} ptt_stat_t;

endpackage

`default_nettype wire

### hdl/periodic_task_timer_table.sv
// Top level of the periodic task timer table.
// Instantiates ptt_ctrl and ptt_datapath; depends on ptt_pkg.
//
// Usage:
// An input transaction is taken at a rising edge with start high and busy low.
// func selects schedule, tick or remove; schedule and remove leave busy low, so a new
// transaction may follow in the next cycle.
// A tick raises busy: the controller walks the slot memory one slot per cycle through
// its single registered read port, then passes through a drain state for the last
// slot's update and a flush state that releases the held event.
// Every due slot gives one result, in ascending slot order, on fired_slot, action and
// last, shown for exactly one cycle with result_valid high. Each event is held back
// until the next one is found, so last marks the final event of the tick; a result
// reaches the output through the read register, the holding stage and the output
// registers, and the final one shows in the first cycle with busy low.
// A tick with nothing due gives no result.
// The receiver cannot stall; results are never held off.
// Reset clears all active bits and the controller at once; no clearing pass is needed.
`default_nettype none

module periodic_task_timer_table #(
	parameter int NUM_SLOTS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  func,
	input  wire  [3:0]  slot,
	input  wire  [23:0] update_period,
	input  wire  [23:0] noop_period,
	input  wire  [15:0] elapsed_ms,
	output logic        result_valid,
	output logic [3:0]  fired_slot,
	output logic        action,
	output logic        last
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	ptt_pkg::ptt_cmd_t  cmd;
	ptt_pkg::ptt_stat_t stat;
	logic [IDX_W-1:0]   rd_addr;

	ptt_ctrl #(
		.NUM_SLOTS(NUM_SLOTS),
		.IDX_W(IDX_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.func(func),
		.busy(busy),
		.cmd(cmd),
		.rd_addr(rd_addr),
		.stat(stat)
	);

	ptt_datapath #(
		.NUM_SLOTS(NUM_SLOTS),
		.IDX_W(IDX_W)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.rd_addr(rd_addr),
		.slot(slot),
		.update_period(update_period),
		.noop_period(noop_period),
		.elapsed_ms(elapsed_ms),
		.stat(stat),
		.result_valid(result_valid),
		.fired_slot(fired_slot),
		.action(action),
		.last(last)
	);

endmodule

`default_nettype wire

### hdl/ptt_ctrl.sv
// Controller state machine of the periodic task timer table: accepts transactions and
// sequences the slot walk of a tick. Depends on ptt_pkg.
`default_nettype none

module ptt_ctrl #(
	parameter int NUM_SLOTS = 16,
	parameter int IDX_W     = 4
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire  [1:0]            func,
	output logic                  busy,
	output ptt_pkg::ptt_cmd_t     cmd,
	output logic [IDX_W-1:0]      rd_addr,
	input  ptt_pkg::ptt_stat_t    stat
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FLUSH
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] cnt_q;
	logic             accept;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign rd_addr = cnt_q;

	always_comb begin
		cmd.sched   = accept && (func == ptt_pkg::FUNC_SCHED);
		cmd.remove  = accept && (func == ptt_pkg::FUNC_REMOVE);
		cmd.tick_ld = accept && (func == ptt_pkg::FUNC_TICK);
		cmd.rd_en   = (state_q == ST_WALK);
		cmd.flush   = (state_q == ST_FLUSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (func == ptt_pkg::FUNC_TICK)) begin
						state_q <= ST_WALK;
						cnt_q   <= '0;
					end
				end
				ST_WALK: begin
					if (cnt_q == IDX_W'(NUM_SLOTS - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !stat.pend)
		else $error("event left pending after tick");

	a_tick_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (func == ptt_pkg::FUNC_TICK)) |=>
		((state_q == ST_WALK) && (cnt_q == '0)))
		else $error("tick did not start walk at slot zero");

	a_flush_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |=> (state_q == ST_IDLE))
		else $error("flush did not return to idle");

endmodule

`default_nettype wire

### hdl/ptt_datapath.sv
// Datapath of the periodic task timer table: slot memory, active bits, countdown update
// and the one-deep event holding stage that marks the final event. Depends on ptt_pkg.
`default_nettype none

module ptt_datapath #(
	parameter int NUM_SLOTS = 16,
	parameter int IDX_W     = 4
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  ptt_pkg::ptt_cmd_t     cmd,
	input  wire  [IDX_W-1:0]      rd_addr,
	input  wire  [3:0]            slot,
	input  wire  [23:0]           update_period,
	input  wire  [23:0]           noop_period,
	input  wire  [15:0]           elapsed_ms,
	output ptt_pkg::ptt_stat_t    stat,
	output logic                  result_valid,
	output logic [3:0]            fired_slot,
	output logic                  action,
	output logic                  last
);

	function automatic logic [31:0] sat_sub(input logic [31:0] v, input logic [15:0] d);
		logic [32:0] r;
		r = {v[31], v} - {17'd0, d};
		if (r[32] != r[31]) begin
			return 32'h8000_0000;
		end
		return r[31:0];
	endfunction

	function automatic logic non_pos(input logic [31:0] v);
		return v[31] || (v == 32'd0);
	endfunction

	ptt_pkg::ptt_entry_t mem_q [NUM_SLOTS];
	ptt_pkg::ptt_entry_t rd_data_s1;
	ptt_pkg::ptt_entry_t wr_data;
	ptt_pkg::ptt_entry_t cur;
	logic [IDX_W-1:0]    wr_addr;
	logic                wr_en;
	logic [IDX_W-1:0]    idx_s1;
	logic                eval_v_s1;
	logic [NUM_SLOTS-1:0] act_q;
	logic [15:0]         dt_q;
	logic                in_range;
	logic [31:0]         ucd_n;
	logic [31:0]         kcd_n;
	logic                live;
	logic                fire_upd;
	logic                fire_nop;
	logic                fire;
	logic                pend_q;
	logic [3:0]          pend_slot_q;
	logic                pend_act_q;
	logic                strobe_q;
	logic [3:0]          fired_slot_q;
	logic                action_q;
	logic                last_q;

	assign in_range = ({3'b000, slot} < 7'(NUM_SLOTS));

	assign cur      = rd_data_s1;
	assign ucd_n    = sat_sub(cur.upd_cd, dt_q);
	assign kcd_n    = sat_sub(cur.nop_cd, dt_q);
	assign live     = eval_v_s1 && act_q[idx_s1];
	assign fire_upd = live && non_pos(ucd_n);
	assign fire_nop = live && !fire_upd && (cur.nop_per != 24'd0) && non_pos(kcd_n);
	assign fire     = fire_upd || fire_nop;

	always_comb begin
		wr_data = cur;
		wr_addr = idx_s1;
		wr_en   = live;
		if (cmd.sched) begin
			wr_en           = in_range;
			wr_addr         = IDX_W'(slot);
			wr_data.upd_per = update_period;
			wr_data.nop_per = noop_period;
			wr_data.upd_cd  = '0;
			wr_data.nop_cd  = '0;
		end else if (fire_upd) begin
			wr_data.upd_cd = {8'd0, cur.upd_per};
			wr_data.nop_cd = {8'd0, cur.nop_per};
		end else if (fire_nop) begin
			wr_data.upd_cd = ucd_n;
			wr_data.nop_cd = {8'd0, cur.nop_per};
		end else begin
			wr_data.upd_cd = ucd_n;
			wr_data.nop_cd = kcd_n;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
		idx_s1 <= rd_addr;
		if (cmd.tick_ld) begin
			dt_q <= elapsed_ms;
		end
		if (fire) begin
			pend_slot_q <= 4'(idx_s1);
			pend_act_q  <= fire_nop ? ptt_pkg::ACT_NOOP : ptt_pkg::ACT_UPDATE;
		end
		fired_slot_q <= pend_slot_q;
		action_q     <= pend_act_q;
		last_q       <= cmd.flush;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q     <= '0;
			eval_v_s1 <= 1'b0;
			pend_q    <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			eval_v_s1 <= cmd.rd_en;
			strobe_q  <= pend_q && (fire || cmd.flush);
			if (fire) begin
				pend_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_q <= 1'b0;
			end
			if (in_range && cmd.sched) begin
				act_q[IDX_W'(slot)] <= 1'b1;
			end else if (in_range && cmd.remove) begin
				act_q[IDX_W'(slot)] <= 1'b0;
			end
		end
	end

	assign stat.pend    = pend_q;
	assign result_valid = strobe_q;
	assign fired_slot   = fired_slot_q;
	assign action       = action_q;
	assign last         = last_q;

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && last_q) |-> !pend_q)
		else $error("final event left another pending");

	a_out_from_pend: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(pend_q))
		else $error("result without a pending event");

	a_no_sched_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		eval_v_s1 |-> !cmd.sched)
		else $error("schedule write collides with slot walk");

endmodule

`default_nettype wire
